[rtl/abbds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abbds_pkg
// shared types and constants of the averaged bang-bang duty stepper
// ----------------------------------------------------------------------------
package abbds_pkg;

   localparam int unsigned SAMPLE_W = 10;

   typedef logic [SAMPLE_W-1:0] sample_type;

   localparam sample_type DUTY_TOP      = sample_type'(1023);
   localparam sample_type DUTY_NEAR_TOP = sample_type'(1022);
   localparam sample_type TARGET_RESET  = sample_type'(70);
   localparam sample_type LEVEL_RESET   = sample_type'(20);
   localparam sample_type SAMPLE_MAX    = sample_type'(1023);

endpackage
`default_nettype wire

[rtl/abbds_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abbds_cell
// one tap of the sample window, hands its sample to the next cell on a shift
// ----------------------------------------------------------------------------
module abbds_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   shift_en,
   input  abbds_pkg::sample_type shift_in,
   output abbds_pkg::sample_type shift_out
);

   abbds_pkg::sample_type tap_ff;
   abbds_pkg::sample_type tap_in;

   assign tap_in = shift_en ? shift_in : tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign shift_out = tap_ff;

endmodule
`default_nettype wire

[rtl/abbds_avg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abbds_avg
// running window sum and truncating division by the window length
// ----------------------------------------------------------------------------
module abbds_avg #(
   parameter int unsigned NUM_SAMPLES = 10
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   sum_load,
   input  abbds_pkg::sample_type sample,
   input  abbds_pkg::sample_type oldest,
   input  wire                   avg_load,
   output abbds_pkg::sample_type avg
);

   localparam int unsigned SUM_W   = $clog2(NUM_SAMPLES * 1023 + 1);
   localparam int unsigned SHIFT   = SUM_W + $clog2(NUM_SAMPLES);
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + NUM_SAMPLES - 1) / NUM_SAMPLES;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;

   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic [RECIP_W-1:0]    recip;
   logic [PROD_W-1:0]     prod;
   abbds_pkg::sample_type avg_ff;
   abbds_pkg::sample_type avg_in;

   assign recip = RECIP_W'(RECIP_L);

   assign sum_in = sum_load ? (sum_ff - SUM_W'(oldest) + SUM_W'(sample)) : sum_ff;

   // quotient by reciprocal multiply, exact over the full sum range
   assign prod   = PROD_W'(sum_ff) * PROD_W'(recip);
   assign avg_in = avg_load ? abbds_pkg::sample_type'(prod >> SHIFT) : avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   assign avg = avg_ff;

endmodule
`default_nettype wire

[rtl/abbds_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abbds_step
// slew-limited level tracking and saturating bang-bang duty update
// ----------------------------------------------------------------------------
module abbds_step #(
   parameter int unsigned INITIAL_DUTY = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step_en,
   input  abbds_pkg::sample_type avg,
   input  abbds_pkg::sample_type target,
   output abbds_pkg::sample_type duty,
   output abbds_pkg::sample_type level
);

   abbds_pkg::sample_type level_ff;
   abbds_pkg::sample_type level_in;
   abbds_pkg::sample_type level_next;
   abbds_pkg::sample_type duty_ff;
   abbds_pkg::sample_type duty_in;
   abbds_pkg::sample_type duty_next;

   always_comb begin
      if (avg > level_ff) begin
         level_next = level_ff + abbds_pkg::sample_type'(1);
      end else if (avg < level_ff) begin
         level_next = level_ff - abbds_pkg::sample_type'(1);
      end else begin
         level_next = level_ff;
      end
   end

   always_comb begin
      if (target > level_next) begin
         duty_next = (duty_ff >= abbds_pkg::DUTY_NEAR_TOP) ? abbds_pkg::DUTY_TOP
                                                          : duty_ff + abbds_pkg::sample_type'(1);
      end else if (target < level_next) begin
         duty_next = (duty_ff <= abbds_pkg::sample_type'(1)) ? '0
                                                             : duty_ff - abbds_pkg::sample_type'(1);
      end else begin
         duty_next = duty_ff;
      end
   end

   assign level_in = step_en ? level_next : level_ff;
   assign duty_in  = step_en ? duty_next : duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= abbds_pkg::LEVEL_RESET;
         duty_ff  <= abbds_pkg::sample_type'(INITIAL_DUTY);
      end else begin
         level_ff <= level_in;
         duty_ff  <= duty_in;
      end
   end

   assign duty  = duty_ff;
   assign level = level_ff;

endmodule
`default_nettype wire

[rtl/averaged_bang_bang_duty_stepper_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// averaged_bang_bang_duty_stepper_core
// moving-average, slew-limited bang-bang duty controller
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_stall  req_sample
//   rsp       out   rsp_valid / rsp_stall  rsp_duty, rsp_tracked_level
//   csr       in    csr_valid / csr_ready  csr_target_level
//
// one sample per cycle sustained while rsp is not stalled; a result
// passes the window sum, reciprocal divide and level and duty step
// registers; a stall on rsp fills the three stages before req is stalled
// synchronous reset clears the window and sum, level to 20, duty to
// INITIAL_DUTY and the setpoint to 70; csr is always ready
// ----------------------------------------------------------------------------
module averaged_bang_bang_duty_stepper_core #(
   parameter int unsigned NUM_SAMPLES  = 10,
   parameter int unsigned INITIAL_DUTY = 0
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [9:0]  req_sample,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [9:0]  rsp_duty,
   output logic [9:0]  rsp_tracked_level,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [9:0]  csr_target_level
);

   logic                  v1_ff, v1_in;
   logic                  v2_ff, v2_in;
   logic                  v3_ff, v3_in;
   logic                  ready1, ready2, ready3;
   logic                  req_xfer, adv2, adv3;
   abbds_pkg::sample_type target_ff, target_in;
   abbds_pkg::sample_type avg;
   abbds_pkg::sample_type duty;
   abbds_pkg::sample_type level;
   abbds_pkg::sample_type chain [NUM_SAMPLES+1];

   // pipeline occupancy and flow
   assign ready3   = !v3_ff || !rsp_stall;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign req_xfer = req_valid && ready1;
   assign adv2     = v1_ff && ready2;
   assign adv3     = v2_ff && ready3;

   assign v1_in = req_xfer || (v1_ff && !ready2);
   assign v2_in = adv2 || (v2_ff && !ready3);
   assign v3_in = adv3 || (v3_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // setpoint register
   assign csr_ready = 1'b1;
   assign target_in = (csr_valid && csr_ready) ? csr_target_level : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= abbds_pkg::TARGET_RESET;
      end else begin
         target_ff <= target_in;
      end
   end

   // sample window as a chain of cells, oldest at the far end
   assign chain[0] = req_sample;

   for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_cell
      abbds_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (req_xfer),
         .shift_in  (chain[i]),
         .shift_out (chain[i+1])
      );
   end

   abbds_avg #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_avg (
      .clock    (clock),
      .reset    (reset),
      .sum_load (req_xfer),
      .sample   (req_sample),
      .oldest   (chain[NUM_SAMPLES]),
      .avg_load (adv2),
      .avg      (avg)
   );

   abbds_step #(
      .INITIAL_DUTY (INITIAL_DUTY)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (adv3),
      .avg     (avg),
      .target  (target_ff),
      .duty    (duty),
      .level   (level)
   );

   assign rsp_valid         = v3_ff;
   assign rsp_duty          = duty;
   assign rsp_tracked_level = level;

endmodule
`default_nettype wire
